FILE: design/tfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// shared constants, stage types and sideband structs of the face normal block
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int CoordFracBits = 16;
  // shift-count offset from the leading-one position to the q32.16 length exponent
  localparam int LenBias       = 15 + 2 * CoordFracBits;

  localparam int CoordW    = 32;
  localparam int DiffW     = 33;
  localparam int ProdW     = 66;
  localparam int MagW      = 65;
  localparam int BlenW     = 7;
  localparam int ExpW      = 9;
  localparam int MantW     = 31;
  localparam int SqW       = 62;

  localparam int SqrtStages = 32;
  localparam int RadW       = 64;
  localparam int RootW      = 32;
  localparam int SqRemW     = 35;

  localparam int DivStages = 34;
  localparam int DivDW     = 64;
  localparam int DivRemW   = 49;
  localparam int DivorW    = 48;
  localparam int QW        = 34;

  localparam int LenW      = 48;
  localparam int NormW     = 32;
  localparam logic [LenW-1:0]  LenMax  = {LenW{1'b1}};
  localparam logic [NormW-1:0] OneQ30  = 32'h4000_0000;
  localparam logic [LenW-1:0]  TwoQ16  = 48'h2_0000;

  typedef struct packed {
    logic [SqRemW-1:0] rem;
    logic [RootW-1:0]  root;
    logic [RadW-1:0]   rad;
  } sqrt_st_t;

  typedef struct packed {
    logic [DivRemW-1:0] rem;
    logic [QW-1:0]      dd;
    logic [DivorW-1:0]  divisor;
    logic [QW-1:0]      quo;
  } div_st_t;

  // travels alongside the square root
  typedef struct packed {
    logic [MantW-1:0]       m0;
    logic [MantW-1:0]       m1;
    logic [MantW-1:0]       m2;
    logic [2:0]             neg;
    logic                   zero;
    logic signed [ExpW-1:0] t;
  } front_sb_t;

  // travels alongside the dividers
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
    logic       len_zero;
  } div_sb_t;

endpackage

FILE: design/tfn_sqrt_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_sqrt_stage
// one registered root digit of the integer square root
// ----------------------------------------------------------------------------
module tfn_sqrt_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tfn_pkg::sqrt_st_t st_i,
  output logic              valid_o,
  output tfn_pkg::sqrt_st_t st_o
);

  logic [tfn_pkg::SqRemW-1:0] rem2;
  logic [tfn_pkg::SqRemW-1:0] trial;
  logic                       ge;
  tfn_pkg::sqrt_st_t          st_d;
  tfn_pkg::sqrt_st_t          st_q;
  logic                       valid_q;

  always_comb begin
    rem2  = {st_i.rem[tfn_pkg::SqRemW-3:0], st_i.rad[tfn_pkg::RadW-1 -: 2]};
    trial = {1'b0, st_i.root, 2'b01};
    ge    = (rem2 >= trial);
    st_d.rem  = ge ? (rem2 - trial) : rem2;
    st_d.root = {st_i.root[tfn_pkg::RootW-2:0], ge};
    st_d.rad  = {st_i.rad[tfn_pkg::RadW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

FILE: design/tfn_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_div_stage
// one registered quotient bit of a restoring divider
// ----------------------------------------------------------------------------
module tfn_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  tfn_pkg::div_st_t st_i,
  output logic             valid_o,
  output tfn_pkg::div_st_t st_o
);

  logic [tfn_pkg::DivRemW-1:0] rem2;
  logic [tfn_pkg::DivRemW-1:0] dvs;
  logic                        ge;
  tfn_pkg::div_st_t            st_d;
  tfn_pkg::div_st_t            st_q;
  logic                        valid_q;

  always_comb begin
    rem2 = {st_i.rem[tfn_pkg::DivRemW-2:0], st_i.dd[tfn_pkg::QW-1]};
    dvs  = {1'b0, st_i.divisor};
    ge   = (rem2 >= dvs);
    st_d.rem     = ge ? (rem2 - dvs) : rem2;
    st_d.dd      = {st_i.dd[tfn_pkg::QW-2:0], 1'b0};
    st_d.divisor = st_i.divisor;
    st_d.quo     = {st_i.quo[tfn_pkg::QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;

endmodule

FILE: design/tfn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_front
// edge vectors, cross product, common normalization and sum of squares
// ----------------------------------------------------------------------------
module tfn_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [31:0]        v0_x_i,
  input  logic signed [31:0]        v0_y_i,
  input  logic signed [31:0]        v0_z_i,
  input  logic signed [31:0]        v1_x_i,
  input  logic signed [31:0]        v1_y_i,
  input  logic signed [31:0]        v1_z_i,
  input  logic signed [31:0]        v2_x_i,
  input  logic signed [31:0]        v2_y_i,
  input  logic signed [31:0]        v2_z_i,
  output logic                      valid_o,
  output logic [tfn_pkg::RadW-1:0]  sum_o,
  output tfn_pkg::front_sb_t        sb_o
);

  localparam int DW = tfn_pkg::DiffW;
  localparam int PW = tfn_pkg::ProdW;
  localparam int MW = tfn_pkg::MagW;

  // stage 1: edges
  logic [6:0] vld_q;
  logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;

  // stage 2: products
  logic signed [PW-1:0] p_q [3];
  logic signed [PW-1:0] r_q [3];

  // stage 3: cross magnitudes
  logic [MW-1:0] mag_d [3];
  logic [MW-1:0] mag_q [3];
  logic [2:0]    neg_d, neg_q, neg4_q, neg5_q, neg6_q, neg7_q;

  // stage 4: leading one
  logic [MW-1:0]                mag4_q [3];
  logic [tfn_pkg::BlenW-1:0]    blen_d, blen_q;
  logic [MW-1:0]                or_all;

  // stage 5: normalize
  logic [tfn_pkg::MantW-1:0]    m_d [3];
  logic [tfn_pkg::MantW-1:0]    m5_q [3];
  logic [tfn_pkg::MantW-1:0]    m6_q [3];
  logic [tfn_pkg::MantW-1:0]    m7_q [3];
  logic signed [tfn_pkg::ExpW-1:0] t_d, t5_q, t6_q, t7_q;
  logic zero5_q, zero6_q, zero7_q;
  logic [MW-1:0] sh_tmp [3];

  // stage 6/7: squares and sum
  logic [tfn_pkg::SqW-1:0]  sq_q [3];
  logic [tfn_pkg::RadW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_comb begin
    logic signed [PW:0] c;
    for (int i = 0; i < 3; i++) begin
      c        = {p_q[i][PW-1], p_q[i]} - {r_q[i][PW-1], r_q[i]};
      neg_d[i] = c[PW];
      mag_d[i] = neg_d[i] ? MW'(-c) : MW'(c);
    end
  end

  always_comb begin
    or_all = mag_q[0] | mag_q[1] | mag_q[2];
    blen_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (or_all[i]) begin
        blen_d = tfn_pkg::BlenW'(i + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (blen_q > tfn_pkg::BlenW'(31)) begin
        sh_tmp[i] = mag4_q[i] >> (blen_q - tfn_pkg::BlenW'(31));
      end else begin
        sh_tmp[i] = mag4_q[i] << (tfn_pkg::BlenW'(31) - blen_q);
      end
      m_d[i] = sh_tmp[i][tfn_pkg::MantW-1:0];
    end
    t_d = $signed({2'b00, blen_q}) - tfn_pkg::ExpW'(tfn_pkg::LenBias);
  end

  always_ff @(posedge clk_i) begin
    ax_q <= {v1_x_i[31], v1_x_i} - {v0_x_i[31], v0_x_i};
    ay_q <= {v1_y_i[31], v1_y_i} - {v0_y_i[31], v0_y_i};
    az_q <= {v1_z_i[31], v1_z_i} - {v0_z_i[31], v0_z_i};
    bx_q <= {v2_x_i[31], v2_x_i} - {v0_x_i[31], v0_x_i};
    by_q <= {v2_y_i[31], v2_y_i} - {v0_y_i[31], v0_y_i};
    bz_q <= {v2_z_i[31], v2_z_i} - {v0_z_i[31], v0_z_i};

    p_q[0] <= ay_q * bz_q;
    r_q[0] <= az_q * by_q;
    p_q[1] <= az_q * bx_q;
    r_q[1] <= ax_q * bz_q;
    p_q[2] <= ax_q * by_q;
    r_q[2] <= ay_q * bx_q;

    mag_q  <= mag_d;
    neg_q  <= neg_d;

    mag4_q <= mag_q;
    blen_q <= blen_d;
    neg4_q <= neg_q;

    m5_q    <= m_d;
    t5_q    <= t_d;
    zero5_q <= (blen_q == '0);
    neg5_q  <= neg4_q;

    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= m5_q[i] * m5_q[i];
    end
    m6_q    <= m5_q;
    t6_q    <= t5_q;
    zero6_q <= zero5_q;
    neg6_q  <= neg5_q;

    sum_q   <= {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    m7_q    <= m6_q;
    t7_q    <= t6_q;
    zero7_q <= zero6_q;
    neg7_q  <= neg6_q;
  end

  assign valid_o  = vld_q[6];
  assign sum_o    = sum_q;
  assign sb_o.m0  = m7_q[0];
  assign sb_o.m1  = m7_q[1];
  assign sb_o.m2  = m7_q[2];
  assign sb_o.neg = neg7_q;
  assign sb_o.zero = zero7_q;
  assign sb_o.t   = t7_q;

endmodule

FILE: design/tfn_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_post
// q32.16 length, threshold compare and divider operand setup
// ----------------------------------------------------------------------------
module tfn_post (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [tfn_pkg::RootW-1:0]   root_i,
  input  tfn_pkg::front_sb_t          sb_i,
  input  logic [tfn_pkg::LenW-1:0]    min_length_i,
  output logic                        valid_o,
  output tfn_pkg::div_st_t            div_o [4],
  output tfn_pkg::div_sb_t            sb_o
);

  localparam int LW = tfn_pkg::LenW;

  logic [1:0]                 vld_q;
  logic [LW-1:0]              len_d, len_q;
  logic                       degen_q;
  logic [tfn_pkg::RootW-1:0]  root_q;
  logic [tfn_pkg::MantW-1:0]  m_q [3];
  logic [2:0]                 neg_q;
  logic [LW+tfn_pkg::RootW-1:0] wide;
  logic [tfn_pkg::ExpW-1:0]   nt;

  tfn_pkg::div_st_t div_d [4];
  tfn_pkg::div_st_t div_q [4];
  tfn_pkg::div_sb_t sb_q;
  logic [tfn_pkg::DivDW-1:0] dd [4];

  always_comb begin
    wide  = '0;
    nt    = '0;
    len_d = '0;
    if (sb_i.t >= $signed(tfn_pkg::ExpW'(LW))) begin
      len_d = tfn_pkg::LenMax;
    end else if (sb_i.t >= 0) begin
      wide  = {{LW{1'b0}}, root_i} << sb_i.t[5:0];
      len_d = (|wide[LW+tfn_pkg::RootW-1:LW]) ? tfn_pkg::LenMax : wide[LW-1:0];
    end else begin
      nt = tfn_pkg::ExpW'(-sb_i.t);
      if (nt < tfn_pkg::ExpW'(tfn_pkg::RootW)) begin
        len_d = {{(LW-tfn_pkg::RootW){1'b0}}, root_i >> nt[4:0]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = ({{(tfn_pkg::DivDW-tfn_pkg::MantW){1'b0}}, m_q[i]} << 30)
            + {{(tfn_pkg::DivDW-tfn_pkg::RootW){1'b0}}, root_q >> 1};
    end
    dd[3] = (tfn_pkg::DivDW'(1) << 33) + {{(tfn_pkg::DivDW-LW){1'b0}}, len_q >> 1};
    for (int i = 0; i < 4; i++) begin
      div_d[i].rem = {{(tfn_pkg::DivRemW-(tfn_pkg::DivDW-tfn_pkg::QW)){1'b0}},
                      dd[i][tfn_pkg::DivDW-1:tfn_pkg::QW]};
      div_d[i].dd  = dd[i][tfn_pkg::QW-1:0];
      div_d[i].quo = '0;
      div_d[i].divisor = (i == 3) ? len_q
                       : {{(tfn_pkg::DivorW-tfn_pkg::RootW){1'b0}}, root_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    // an all-zero cross product is degenerate even with a zero threshold
    degen_q <= sb_i.zero | (len_d < min_length_i);
    root_q  <= root_i;
    m_q[0]  <= sb_i.m0;
    m_q[1]  <= sb_i.m1;
    m_q[2]  <= sb_i.m2;
    neg_q   <= sb_i.neg;

    div_q          <= div_d;
    sb_q.neg       <= neg_q;
    sb_q.degen     <= degen_q;
    sb_q.len_zero  <= (len_q == '0);
  end

  assign valid_o = vld_q[1];
  assign div_o   = div_q;
  assign sb_o    = sb_q;

endmodule

FILE: design/triangle_face_normal_and_area.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_and_area
// unit face normal, inverse area and degenerate flag of one triangle per cycle
// throughput: one request per cycle, set by the 32-stage square root and
// the 34-stage dividers, each one bit per registered stage; busy is never high
// reset clears all valid bits and sets min_length to 1; no results while in reset
// ----------------------------------------------------------------------------
module triangle_face_normal_and_area (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] v0_x_i,
  input  logic signed [31:0] v0_y_i,
  input  logic signed [31:0] v0_z_i,
  input  logic signed [31:0] v1_x_i,
  input  logic signed [31:0] v1_y_i,
  input  logic signed [31:0] v1_z_i,
  input  logic signed [31:0] v2_x_i,
  input  logic signed [31:0] v2_y_i,
  input  logic signed [31:0] v2_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [47:0]        cfg_data_i,
  output logic               done_o,
  output logic signed [31:0] normal_x_o,
  output logic signed [31:0] normal_y_o,
  output logic signed [31:0] normal_z_o,
  output logic [47:0]        area_recip_o,
  output logic               degenerate_o
);

  localparam int SN = tfn_pkg::SqrtStages;
  localparam int DN = tfn_pkg::DivStages;

  logic [tfn_pkg::LenW-1:0] min_len_q;

  logic                     fr_vld;
  logic [tfn_pkg::RadW-1:0] fr_sum;
  tfn_pkg::front_sb_t       fr_sb;

  logic                     sq_vld [SN+1];
  tfn_pkg::sqrt_st_t        sq_st  [SN+1];
  tfn_pkg::front_sb_t       sq_sb_q [SN];

  logic                     po_vld;
  tfn_pkg::div_st_t         po_div [4];
  tfn_pkg::div_sb_t         po_sb;

  logic                     dv_vld [4][DN+1];
  tfn_pkg::div_st_t         dv_st  [4][DN+1];
  tfn_pkg::div_sb_t         dv_sb_q [DN];

  logic                     done_q;
  logic [tfn_pkg::NormW-1:0] nrm_d [3];
  logic [tfn_pkg::NormW-1:0] nrm_q [3];
  logic [tfn_pkg::LenW-1:0] inv_d, inv_q;
  logic                     degen_q;
  logic [tfn_pkg::NormW-1:0] n_mag;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= tfn_pkg::LenW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_len_q <= cfg_data_i;
    end
  end

  tfn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .v0_x_i  (v0_x_i),
    .v0_y_i  (v0_y_i),
    .v0_z_i  (v0_z_i),
    .v1_x_i  (v1_x_i),
    .v1_y_i  (v1_y_i),
    .v1_z_i  (v1_z_i),
    .v2_x_i  (v2_x_i),
    .v2_y_i  (v2_y_i),
    .v2_z_i  (v2_z_i),
    .valid_o (fr_vld),
    .sum_o   (fr_sum),
    .sb_o    (fr_sb)
  );

  assign sq_vld[0]      = fr_vld;
  assign sq_st[0].rem   = '0;
  assign sq_st[0].root  = '0;
  assign sq_st[0].rad   = fr_sum;

  for (genvar k = 0; k < SN; k++) begin : g_sqrt
    tfn_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_vld[k]),
      .st_i    (sq_st[k]),
      .valid_o (sq_vld[k+1]),
      .st_o    (sq_st[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    sq_sb_q[0] <= fr_sb;
    for (int k = 1; k < SN; k++) begin
      sq_sb_q[k] <= sq_sb_q[k-1];
    end
  end

  tfn_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (sq_vld[SN]),
    .root_i       (sq_st[SN].root),
    .sb_i         (sq_sb_q[SN-1]),
    .min_length_i (min_len_q),
    .valid_o      (po_vld),
    .div_o        (po_div),
    .sb_o         (po_sb)
  );

  // lanes 0..2 divide the normal components, lane 3 forms the inverse area
  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign dv_vld[l][0] = po_vld;
    assign dv_st[l][0]  = po_div[l];
    for (genvar k = 0; k < DN; k++) begin : g_div
      tfn_div_stage u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (dv_vld[l][k]),
        .st_i    (dv_st[l][k]),
        .valid_o (dv_vld[l][k+1]),
        .st_o    (dv_st[l][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    dv_sb_q[0] <= po_sb;
    for (int k = 1; k < DN; k++) begin
      dv_sb_q[k] <= dv_sb_q[k-1];
    end
  end

  always_comb begin
    n_mag = '0;
    for (int i = 0; i < 3; i++) begin
      n_mag = dv_st[i][DN].quo[tfn_pkg::NormW-1:0];
      nrm_d[i] = dv_sb_q[DN-1].neg[i] ? (-n_mag) : n_mag;
    end
    inv_d = dv_sb_q[DN-1].len_zero ? tfn_pkg::LenMax
          : {{(tfn_pkg::LenW-tfn_pkg::QW){1'b0}}, dv_st[3][DN].quo};
    if (dv_sb_q[DN-1].degen) begin
      nrm_d[0] = '0;
      nrm_d[1] = '0;
      nrm_d[2] = tfn_pkg::OneQ30;
      inv_d    = tfn_pkg::TwoQ16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_vld[0][DN];
    end
  end

  always_ff @(posedge clk_i) begin
    nrm_q   <= nrm_d;
    inv_q   <= inv_d;
    degen_q <= dv_sb_q[DN-1].degen;
  end

  assign done_o       = done_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign area_recip_o = inv_q;
  assign degenerate_o = degen_q;

endmodule

FILE: tb/sv/tb_triangle_face_normal_and_area.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_face_normal_and_area
// self-checking bench: drives triangles with random gaps, predicts the unit
// normal, inverse area and degenerate flag, and compares every done_o strobe
// ----------------------------------------------------------------------------
module tb_triangle_face_normal_and_area;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic [47:0]        inv;
    logic               degen;
  } face_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] v0_x_i = '0, v0_y_i = '0, v0_z_i = '0;
  logic signed [31:0] v1_x_i = '0, v1_y_i = '0, v1_z_i = '0;
  logic signed [31:0] v2_x_i = '0, v2_y_i = '0, v2_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [47:0] cfg_data_i = '0;
  logic done_o;
  logic signed [31:0] normal_x_o, normal_y_o, normal_z_o;
  logic [47:0] area_recip_o;
  logic degenerate_o;

  face_t face_q[$];
  logic [47:0] min_len = 48'd1;
  int errors = 0;
  int n_sent = 0;
  int n_degen = 0;

  always #10 clk_i = ~clk_i;

  triangle_face_normal_and_area u_dut (.*);

  function automatic logic [64:0] mag66(logic signed [65:0] v, output logic neg);
    neg = v[65];
    return neg ? 65'(-v) : 65'(v);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic face_t predict_face(logic signed [31:0] v[9]);
    logic signed [65:0] d[6], c[3];
    logic [64:0] mg[3];
    logic [2:0] ng;
    logic [63:0] m[3], sum, r, lq;
    logic [127:0] num;
    int b, sh, t, bl;
    face_t f;
    for (int i = 0; i < 3; i++) begin
      d[i]   = 66'(v[3+i]) - 66'(v[i]);
      d[3+i] = 66'(v[6+i]) - 66'(v[i]);
    end
    c[0] = d[1] * d[5] - d[2] * d[4];
    c[1] = d[2] * d[3] - d[0] * d[5];
    c[2] = d[0] * d[4] - d[1] * d[3];
    b = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = mag66(c[i], ng[i]);
      bl = 0;
      for (int k = 0; k < 65; k++) if (mg[i][k]) bl = k + 1;
      if (bl > b) b = bl;
    end
    f = '{0, 0, 32'sh4000_0000, 48'h2_0000, 1'b1};
    if (b == 0) return f;
    sh = b - 31;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = sh <= 0 ? 64'(mg[i] << (-sh)) : 64'(mg[i] >> sh);
      sum += m[i] * m[i];
    end
    r = isqrt(sum);
    t = sh + 16 - 2 * tfn_pkg::CoordFracBits;
    if (t >= 48) lq = 64'(tfn_pkg::LenMax);
    else if (t >= 0) begin
      lq = (r > (64'(tfn_pkg::LenMax) >> t)) ? 64'(tfn_pkg::LenMax) : (r << t);
    end
    else lq = (-t >= 64) ? 0 : (r >> (-t));
    if (lq < 64'(min_len)) return f;
    num = 0;
    for (int i = 0; i < 3; i++) begin
      num = (128'(m[i]) * (128'd1 << 30) + 128'(r >> 1)) / 128'(r);
      f.nx = f.ny; f.ny = f.nz;
      f.nz = ng[i] ? -32'(num) : 32'(num);
    end
    f.inv = lq == 0 ? tfn_pkg::LenMax : 48'(((64'd1 << 33) + (lq >> 1)) / lq);
    f.degen = 1'b0;
    return f;
  endfunction

  // result checker: the block cannot be stalled, so every strobe is taken
  always @(posedge clk_i) begin
    face_t e;
    if (done_o) begin
      if (face_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = face_q.pop_front();
        if (normal_x_o !== e.nx) begin
          $error("normal_x exp %h got %h", e.nx, normal_x_o); errors++;
        end
        if (normal_y_o !== e.ny) begin
          $error("normal_y exp %h got %h", e.ny, normal_y_o); errors++;
        end
        if (normal_z_o !== e.nz) begin
          $error("normal_z exp %h got %h", e.nz, normal_z_o); errors++;
        end
        if (area_recip_o !== e.inv) begin
          $error("area_recip exp %h got %h", e.inv, area_recip_o); errors++;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate exp %b got %b", e.degen, degenerate_o); errors++;
        end
      end
    end
  end

  // start drops only when a gap follows, so it is driven once per time step
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_triangle(logic signed [31:0] v[9]);
    face_t f;
    f = predict_face(v);
    if (f.degen) n_degen++;
    v0_x_i <= v[0]; v0_y_i <= v[1]; v0_z_i <= v[2];
    v1_x_i <= v[3]; v1_y_i <= v[4]; v1_z_i <= v[5];
    v2_x_i <= v[6]; v2_y_i <= v[7]; v2_z_i <= v[8];
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    face_q.insert(face_q.size(), f);
    n_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (face_q.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic write_min_length(logic [47:0] val);
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    min_len = val;
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      2: return $signed($urandom_range(0, 255)) - 128;
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] v[9];
    v = '{default: 0};
    send_triangle(v);
    v = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0};
    send_triangle(v);
    v = '{0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 0};
    send_triangle(v);
    v = '{0, 0, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
    send_triangle(v);
    // collinear vertices
    v = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
    send_triangle(v);
    // tiny triangle, length truncates to zero
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(v);
    // extreme corners, length saturates
    v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    send_triangle(v);
    v = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000};
    send_triangle(v);
    v = '{-1, -1, -1, 32'sh7FFF_FFFF, 0, 0, 0, 32'sh8000_0000, -1};
    send_triangle(v);
    drain();
  endtask

  task automatic test_zero_threshold();
    logic signed [31:0] v[9];
    write_min_length(48'd0);
    v = '{default: 0};
    send_triangle(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(v);
    v = '{5, 0, 0, 5, 3, 0, 5, 0, 7};
    send_triangle(v);
    drain();
  endtask

  task automatic test_random(int count, logic [47:0] thr);
    logic signed [31:0] v[9];
    int mode;
    write_min_length(thr);
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(0, 9);
      mode = mode < 5 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3;
      foreach (v[i]) v[i] = rand_coord(($urandom_range(0, 7) == 0) ? 3 : mode);
      if ($urandom_range(0, 19) == 0) v[6 + $urandom_range(0, 2)] = v[$urandom_range(0, 2)];
      send_triangle(v);
      idle_gap();
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_threshold();
    test_random(300, 48'd1);
    test_random(250, 48'd0);
    test_random(250, {16'd0, 32'h0001_0000});
    test_random(150, {$urandom, 16'h0});
    test_random(100, tfn_pkg::LenMax);
    test_random(100, {16'($urandom_range(0, 16'hFFFF)), $urandom});
    $display("sent %0d triangles (%0d degenerate) over seven threshold settings",
             n_sent, n_degen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
